// ===== hw/rtl/ruf_pkg.sv =====
// Package: shared constants, operation codes, controller states and command/status structs.
`default_nettype none

package ruf_pkg;

  // Store geometry
  localparam int NODES       = 1024;
  localparam int NODE_W      = $clog2(NODES);
  localparam int WORD_W      = NODE_W + 2;
  localparam int SIZE_W      = NODE_W + 1;
  localparam int STACK_DEPTH = 2 * (NODES - 1);
  localparam int STACK_W     = $clog2(STACK_DEPTH + 1);
  localparam int REC_W       = NODE_W + WORD_W;
  localparam int OP_W        = 3;

  // Highest history depth at which a union still has room for its two records
  localparam logic [STACK_W-1:0] TOP_JOIN_MAX = STACK_W'(STACK_DEPTH - 2);
  localparam logic [NODE_W-1:0]  LAST_NODE    = NODE_W'(NODES - 1);

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_FIND     = 3'd0,
    OP_UNION    = 3'd1,
    OP_SIZE     = 3'd2,
    OP_TIME     = 3'd3,
    OP_ROLLBACK = 3'd4
  } ruf_op_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_A_LOAD,
    ST_A_WALK,
    ST_B_LOAD,
    ST_B_WALK,
    ST_CHECK,
    ST_JOIN_HI,
    ST_JOIN_LO,
    ST_RB_READ,
    ST_RB_WRITE,
    ST_FIND_LOAD,
    ST_FIND_WALK
  } ruf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic latch;
    logic walk_load;
    logic walk_from_b;
    logic walk_step;
    logic save_a;
    logic save_b;
    logic join_hi;
    logic join_lo;
    logic rb_read;
    logic rb_write;
    logic capture;
  } ruf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic            clr_last;
    logic            walk_done;
    logic            can_merge;
    logic            rb_more;
    logic [OP_W-1:0] op;
  } ruf_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ruf_ctrl.sv =====
// Controller: sequences clearing, tree walks, union writes and rollback pops.
`default_nettype none

module ruf_ctrl
  import ruf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire ruf_sts_t sts,
  output ruf_cmd_t      cmd,
  output logic          busy
);

  ruf_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:     if (sts.clr_last) state_next = ST_IDLE;
      ST_IDLE:      if (start) state_next = ST_DECODE;
      ST_DECODE: begin
        unique case (sts.op)
          OP_UNION:    state_next = ST_A_LOAD;
          OP_ROLLBACK: state_next = ST_RB_READ;
          default:     state_next = ST_FIND_LOAD;
        endcase
      end
      ST_A_LOAD:    state_next = ST_A_WALK;
      ST_A_WALK:    if (sts.walk_done) state_next = ST_B_LOAD;
      ST_B_LOAD:    state_next = ST_B_WALK;
      ST_B_WALK:    if (sts.walk_done) state_next = ST_CHECK;
      ST_CHECK:     state_next = sts.can_merge ? ST_JOIN_HI : ST_FIND_LOAD;
      ST_JOIN_HI:   state_next = ST_JOIN_LO;
      ST_JOIN_LO:   state_next = ST_FIND_LOAD;
      ST_RB_READ:   state_next = sts.rb_more ? ST_RB_WRITE : ST_FIND_LOAD;
      ST_RB_WRITE:  state_next = ST_RB_READ;
      ST_FIND_LOAD: state_next = ST_FIND_WALK;
      ST_FIND_WALK: if (sts.walk_done) state_next = ST_IDLE;
      default:      state_next = ST_CLEAR;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_CLEAR:     cmd.clear = 1'b1;
      ST_IDLE:      cmd.latch = start;
      ST_A_LOAD:    cmd.walk_load = 1'b1;
      ST_A_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.save_a    = sts.walk_done;
      end
      ST_B_LOAD: begin
        cmd.walk_load   = 1'b1;
        cmd.walk_from_b = 1'b1;
      end
      ST_B_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.save_b    = sts.walk_done;
      end
      ST_JOIN_HI:   cmd.join_hi = 1'b1;
      ST_JOIN_LO:   cmd.join_lo = 1'b1;
      ST_RB_READ:   cmd.rb_read = sts.rb_more;
      ST_RB_WRITE:  cmd.rb_write = 1'b1;
      ST_FIND_LOAD: cmd.walk_load = 1'b1;
      ST_FIND_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.capture   = sts.walk_done;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ruf_datapath.sv =====
// Datapath: link table, undo stack, walk cursor, history depth and result registers.
`default_nettype none

module ruf_datapath
  import ruf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ruf_cmd_t            cmd,
  input  wire logic [OP_W-1:0]     op,
  input  wire logic [NODE_W-1:0]   node_a,
  input  wire logic [NODE_W-1:0]   node_b,
  input  wire logic [STACK_W-1:0]  rollback_time,
  output ruf_sts_t                 sts,
  output logic                     done,
  output logic [NODE_W-1:0]        root,
  output logic                     merged,
  output logic [SIZE_W-1:0]        set_size,
  output logic [STACK_W-1:0]       history_depth
);

  // Link table: root holds minus its size, other nodes hold their parent
  logic        [WORD_W-1:0] link_mem [NODES];
  logic signed [WORD_W-1:0] link_q;
  logic        [NODE_W-1:0] rd_addr;
  logic                     link_we;
  logic        [NODE_W-1:0] link_waddr;
  logic        [WORD_W-1:0] link_wdata;

  // Undo stack: {node, old word}
  logic [REC_W-1:0]   stack_mem [STACK_DEPTH];
  logic [REC_W-1:0]   stk_q;
  logic [STACK_W-1:0] top;
  logic [STACK_W-1:0] top_m1;
  logic [STACK_W-1:0] target;
  logic [STACK_W-1:0] tgt_clamp;

  logic [NODE_W-1:0]  clr_cnt;
  logic [OP_W-1:0]    op_q;
  logic [NODE_W-1:0]  a_q, b_q, cur;
  logic [NODE_W-1:0]  ra, rb;
  logic signed [WORD_W-1:0] wa, wb;
  logic               merged_q;

  // Union ordering: hi is the surviving root, lo is hung under it
  logic                     a_big;
  logic        [NODE_W-1:0] hi_node, lo_node;
  logic signed [WORD_W-1:0] hi_word, lo_word, sum_word;
  logic        [WORD_W-1:0] neg_word;

  assign a_big    = (wa < wb);
  assign hi_node  = a_big ? ra : rb;
  assign lo_node  = a_big ? rb : ra;
  assign hi_word  = a_big ? wa : wb;
  assign lo_word  = a_big ? wb : wa;
  assign sum_word = hi_word + lo_word;
  assign top_m1   = top - STACK_W'(1);
  assign neg_word = WORD_W'(-link_q);
  assign tgt_clamp = (rollback_time > top) ? top : rollback_time;

  // Status back to the controller
  assign sts.clr_last  = (clr_cnt == LAST_NODE);
  assign sts.walk_done = link_q[WORD_W-1];
  assign sts.can_merge = (ra != rb) && (top <= TOP_JOIN_MAX);
  assign sts.rb_more   = (top > target);
  assign sts.op        = op_q;

  // Walk address: start node on load, else follow the parent just read
  always_comb begin
    if (cmd.walk_load) begin
      rd_addr = cmd.walk_from_b ? b_q : a_q;
    end else begin
      rd_addr = link_q[NODE_W-1:0];
    end
  end

  // Link table write port
  always_comb begin
    link_we    = 1'b1;
    link_waddr = clr_cnt;
    link_wdata = '1;
    if (cmd.join_hi) begin
      link_waddr = hi_node;
      link_wdata = sum_word;
    end else if (cmd.join_lo) begin
      link_waddr = lo_node;
      link_wdata = WORD_W'(hi_node);
    end else if (cmd.rb_write) begin
      link_waddr = stk_q[REC_W-1:WORD_W];
      link_wdata = stk_q[WORD_W-1:0];
    end else if (!cmd.clear) begin
      link_we = 1'b0;
    end
  end

  // Link table memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_q <= link_mem[rd_addr];
  end

  // Undo stack memory
  always_ff @(posedge clk) begin
    if (cmd.join_hi) begin
      stack_mem[top] <= {hi_node, hi_word};
    end else if (cmd.join_lo) begin
      stack_mem[top] <= {lo_node, lo_word};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rb_read) begin
      stk_q <= stack_mem[top_m1];
    end
  end

  // Control registers: clear sweep, history depth, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      top     <= '0;
      done    <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + NODE_W'(1);
      end
      if (cmd.join_hi || cmd.join_lo) begin
        top <= top + STACK_W'(1);
      end else if (cmd.rb_read) begin
        top <= top_m1;
      end
      done <= cmd.capture;
    end
  end

  // Request beat, walk cursor and union operands
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q     <= op;
      a_q      <= node_a;
      b_q      <= node_b;
      target   <= {tgt_clamp[STACK_W-1:1], 1'b0};
      merged_q <= 1'b0;
    end
    if (cmd.join_hi) begin
      merged_q <= 1'b1;
    end
    if (cmd.walk_load || (cmd.walk_step && !link_q[WORD_W-1])) begin
      cur <= rd_addr;
    end
    if (cmd.save_a) begin
      ra <= cur;
      wa <= link_q;
    end
    if (cmd.save_b) begin
      rb <= cur;
      wb <= link_q;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      root          <= cur;
      merged        <= merged_q;
      set_size      <= neg_word[SIZE_W-1:0];
      history_depth <= top;
    end
  end

  // Checks
  a_done_follows_capture: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.capture))
    else $error("result strobe without a capture");

  a_depth_even: assert property (@(posedge clk) disable iff (rst)
    done |-> !history_depth[0])
    else $error("history depth reported odd");

  a_top_bounded: assert property (@(posedge clk) disable iff (rst)
    top <= STACK_W'(STACK_DEPTH))
    else $error("undo stack overflow");

  a_size_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (set_size != '0))
    else $error("zero set size reported");

  a_join_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.join_hi |=> cmd.join_lo)
    else $error("union wrote only one record");

endmodule

`default_nettype wire

// ===== hw/rtl/rollback_union_find_core.sv =====
// Top level: disjoint-set store with union by size and rollback of unions.
//
//   channel   ports                                        handshake
//   request   op, node_a, node_b, rollback_time            start & !busy
//   result    root, merged, set_size, history_depth        done (one cycle)
//
// Find, size, time and unknown ops walk from node_a to its root and then raise done; the
// tree depth is at most log2 of the node count, and each tree level costs one read of
// the link table, whose registered read sets the pace.
// busy drops with done, so the next request can go in at the edge that ends done.
// Union walks both trees, writes two records if the roots differ and the stack has room,
// then walks again. Rollback pops records off the undo stack one at a time, then finds.
// After reset a clearing pass over all 1024 nodes fills the link table; busy is high
// meanwhile. The receiver cannot stall: done is a single-cycle strobe.
`default_nettype none

module rollback_union_find_core
  import ruf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [OP_W-1:0]    op,
  input  wire logic [NODE_W-1:0]  node_a,
  input  wire logic [NODE_W-1:0]  node_b,
  input  wire logic [STACK_W-1:0] rollback_time,
  output logic                    done,
  output logic [NODE_W-1:0]       root,
  output logic                    merged,
  output logic [SIZE_W-1:0]       set_size,
  output logic [STACK_W-1:0]      history_depth
);

  ruf_cmd_t cmd;
  ruf_sts_t sts;

  ruf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ruf_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .op            (op),
    .node_a        (node_a),
    .node_b        (node_b),
    .rollback_time (rollback_time),
    .sts           (sts),
    .done          (done),
    .root          (root),
    .merged        (merged),
    .set_size      (set_size),
    .history_depth (history_depth)
  );

endmodule

`default_nettype wire

// ===== sim/tb_rollback_union_find_core.sv =====
// Testbench for the rollback union-find core: directed, deep-tree and random requests.
`default_nettype none

module tb_rollback_union_find_core
  import ruf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Codes the block decodes like a find
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam int STALL_LIMIT    = 20000;
  localparam int RANDOM_BEATS   = 300;
  localparam int TAIL_CYCLES    = 64;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [NODE_W-1:0]  root;
    logic               merged;
    logic [SIZE_W-1:0]  set_size;
    logic [STACK_W-1:0] history_depth;
  } uf_result_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    op;
  logic [NODE_W-1:0]  node_a;
  logic [NODE_W-1:0]  node_b;
  logic [STACK_W-1:0] rollback_time;
  logic               done;
  logic [NODE_W-1:0]  root;
  logic               merged;
  logic [SIZE_W-1:0]  set_size;
  logic [STACK_W-1:0] history_depth;

  // Shadow forest: a root holds minus its set size, other nodes their parent
  int          parent_word [NODES];
  int unsigned undo_node   [STACK_DEPTH];
  int          undo_word   [STACK_DEPTH];
  int unsigned undo_depth;

  uf_result_t  expected_results[$];
  int unsigned requests_sent;
  int unsigned mismatch_count;
  int unsigned stall_cycles;
  bit          gaps_enabled;

  rollback_union_find_core DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .node_a        (node_a),
    .node_b        (node_b),
    .rollback_time (rollback_time),
    .done          (done),
    .root          (root),
    .merged        (merged),
    .set_size      (set_size),
    .history_depth (history_depth)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Walk parent links up to the root
  function automatic int unsigned root_of(input int unsigned v);
    int unsigned r;
    r = v;
    for (int guard = 0; guard < NODES; guard++) begin
      if (parent_word[r] < 0) break;
      r = parent_word[r];
    end
    return r;
  endfunction

  function automatic void push_undo(input int unsigned n, input int w);
    undo_node[undo_depth] = n;
    undo_word[undo_depth] = w;
    undo_depth++;
  endfunction

  // Union by size; on a tie node_a's root goes under node_b's
  function automatic bit join_roots(input int unsigned a, input int unsigned b);
    int unsigned r1;
    int unsigned r2;
    int unsigned swap;
    r1 = root_of(a);
    r2 = root_of(b);
    if (r1 == r2 || undo_depth + 2 > STACK_DEPTH) return 1'b0;
    if (-parent_word[r1] > -parent_word[r2]) begin
      swap = r1;
      r1 = r2;
      r2 = swap;
    end
    push_undo(r2, parent_word[r2]);
    push_undo(r1, parent_word[r1]);
    parent_word[r2] += parent_word[r1];
    parent_word[r1] = r2;
    return 1'b1;
  endfunction

  // Pop whole unions back to the clamped, even depth
  function automatic void roll_back_to(input int unsigned t);
    int unsigned target;
    target = (t > undo_depth) ? undo_depth : t;
    target = target & ~32'd1;
    while (undo_depth > target) begin
      undo_depth--;
      parent_word[undo_node[undo_depth]] = undo_word[undo_depth];
    end
  endfunction

  function automatic uf_result_t predict_request(input logic [OP_W-1:0] req_op,
                                                 input int unsigned a,
                                                 input int unsigned b,
                                                 input int unsigned t);
    uf_result_t  res;
    bit          joined;
    int unsigned r;
    joined = 1'b0;
    if (req_op == OP_UNION) joined = join_roots(a, b);
    else if (req_op == OP_ROLLBACK) roll_back_to(t);
    r = root_of(a);
    res.root          = NODE_W'(r);
    res.merged        = joined;
    res.set_size      = SIZE_W'(-parent_word[r]);
    res.history_depth = STACK_W'(undo_depth);
    return res;
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!gaps_enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_request(input logic [OP_W-1:0] req_op, input int unsigned a,
                              input int unsigned b, input int unsigned t);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start         <= 1'b1;
    op            <= req_op;
    node_a        <= NODE_W'(a);
    node_b        <= NODE_W'(b);
    rollback_time <= STACK_W'(t);
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(predict_request(req_op, a % NODES, b % NODES,
                                               t % (1 << STACK_W)));
    requests_sent++;
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Merge 2**log_span consecutive nodes pairwise, level by level (equal sizes)
  task automatic build_balanced(input int unsigned base, input int unsigned log_span);
    int unsigned span;
    int unsigned x;
    int unsigned y;
    span = 1 << log_span;
    for (int unsigned step = 1; step < span; step = step * 2) begin
      for (int unsigned i = 0; i < span; i = i + 2 * step) begin
        x = (base + i) % NODES;
        y = (base + i + step) % NODES;
        if ($urandom_range(0, 1)) send_request(OP_UNION, x, y, $urandom_range(0, 2047));
        else send_request(OP_UNION, y, x, $urandom_range(0, 2047));
      end
    end
  endtask

  task automatic report_mismatch(input string why, input uf_result_t want,
                                 input uf_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t mismatch (%s): expected root=%0d merged=%0d size=%0d depth=%0d,",
               $realtime, why, want.root, want.merged, want.set_size, want.history_depth,
               " got root=%0d merged=%0d size=%0d depth=%0d",
               got.root, got.merged, got.set_size, got.history_depth);
  endtask

  // Result checker: every done beat against the oldest prediction
  always @(posedge clk) begin : result_check
    uf_result_t got;
    uf_result_t want;
    if (!rst && done) begin
      got.root          = root;
      got.merged        = merged;
      got.set_size      = set_size;
      got.history_depth = history_depth;
      if (expected_results.size() == 0) begin
        want = '0;
        report_mismatch("no result pending", want, got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) report_mismatch("field", want, got);
      end
    end
  end

  // Watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Fresh store, ties, same set, odd and oversized rollback depths, spare codes
  task automatic test_directed_cases();
    send_request(OP_FIND, 0, 0, 0);
    send_request(OP_SIZE, 1023, 1023, 2047);
    send_request(OP_TIME, 0, 1023, 0);
    send_request(OP_UNION, 0, 1023, 0);
    send_request(OP_UNION, 1023, 0, 0);
    send_request(OP_UNION, 1, 2, 0);
    send_request(OP_UNION, 2, 0, 0);
    send_request(OP_FIND, 1, 0, 0);
    send_request(OP_UNION, 5, 1, 0);
    send_request(OP_UNION, 0, 7, 0);
    send_request(OP_SIZE, 7, 0, 0);
    send_request(OP_ROLLBACK, 0, 0, 9);
    send_request(OP_ROLLBACK, 1, 0, 2047);
    send_request(OP_SIZE, 0, 0, 0);
    send_request(OP_ROLLBACK, 2, 0, 3);
    send_request(OP_FIND, 2, 1023, 0);
    for (int code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++)
      send_request(OP_W'(code), 0, 1023, 2047);
    send_request(OP_ROLLBACK, 1023, 1023, 0);
    send_request(OP_TIME, 1023, 0, 2047);
    drain_results();
  endtask

  // One large balanced set: deep walks, big sizes, long history
  task automatic test_full_tree();
    int unsigned base;
    base = $urandom_range(0, NODES - 1);
    build_balanced(base, NODE_W - 2);
    for (int i = 0; i < 4; i++) send_request(OP_FIND, $urandom_range(0, 1023), 0, 0);
    send_request(OP_SIZE, base, 0, 0);
    send_request(OP_UNION, $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
    send_request(OP_TIME, 0, 0, 0);
    send_request(OP_ROLLBACK, base, 0, 2047);
    send_request(OP_ROLLBACK, base, 0, 1023);
    send_request(OP_FIND, $urandom_range(0, 1023), 0, 0);
    send_request(OP_ROLLBACK, base, 0, 0);
    drain_results();
  endtask

  // Balanced builds with queries and undo, mixed with random requests
  task automatic test_random_mix();
    int unsigned goal;
    int unsigned base;
    int unsigned log_span;
    int unsigned mark;
    goal = requests_sent + RANDOM_BEATS;
    while (requests_sent < goal) begin
      gaps_enabled = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 9)) inside
        [0:3]: begin
          base = $urandom_range(0, NODES - 1);
          log_span = $urandom_range(1, 6);
          mark = undo_depth;
          build_balanced(base, log_span);
          repeat ($urandom_range(1, 3))
            send_request($urandom_range(0, 1) ? OP_FIND : OP_SIZE,
                         base + $urandom_range(0, (1 << log_span) - 1),
                         $urandom_range(0, 1023), $urandom_range(0, 2047));
          if ($urandom_range(0, 1))
            send_request(OP_ROLLBACK, base, 0, mark + $urandom_range(0, 1));
        end
        [4:5]: begin
          send_request(OP_ROLLBACK, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 1) ? $urandom_range(0, undo_depth + 3)
                                            : $urandom_range(0, 2047));
        end
        default: begin
          send_request(OP_W'($urandom_range(0, 7)), $urandom_range(0, 1023),
                       $urandom_range(0, 1023), $urandom_range(0, 2047));
        end
      endcase
      if ($urandom_range(0, 15) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    op             = OP_FIND;
    node_a         = '0;
    node_b         = '0;
    rollback_time  = '0;
    requests_sent  = 0;
    mismatch_count = 0;
    stall_cycles   = 0;
    gaps_enabled   = 1'b1;
    undo_depth     = 0;
    for (int i = 0; i < NODES; i++) parent_word[i] = -1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_full_tree();
    test_random_mix();

    // Catch stray beats after the last result
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/ruf_pkg.sv
hw/rtl/ruf_ctrl.sv
hw/rtl/ruf_datapath.sv
hw/rtl/rollback_union_find_core.sv
sim/tb_rollback_union_find_core.sv
